@@ rtl/spq_pkg.sv @@
// shared types, widths and codes of the stable priority queue
package spq_pkg;

   // field widths of the request and response words
   localparam int unsigned VALUE_W  = 8;
   localparam int unsigned PRIO_W   = 3;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 5;

   // priority range and number of priority classes
   localparam logic [PRIO_W-1:0] PRIO_MIN    = 3'd1;
   localparam logic [PRIO_W-1:0] PRIO_MAX    = 3'd5;
   localparam int unsigned       NUM_CLASSES = 5;
   localparam int unsigned       CLS_W       = 3;

   // default number of stored entries
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;

   // operation codes
   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

@@ rtl/spq_channels_if.sv @@
// request and response channel interfaces of the stable priority queue
interface spq_req_if
   import spq_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [VALUE_W-1:0] item_value;
   logic [PRIO_W-1:0]  item_priority;

   modport source (output valid, output operation, output item_value,
                   output item_priority, input ready);
   modport sink   (input valid, input operation, input item_value,
                   input item_priority, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  out_value;
   logic [PRIO_W-1:0]   out_priority;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output out_value,
                   output out_priority, output occupancy, input ready);
   modport sink   (input valid, input status, input out_value,
                   input out_priority, input occupancy, output ready);
endinterface

@@ rtl/spq_ram.sv @@
// generic single write port ram with a registered read port
module spq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/stable_priority_queue.sv @@
// Stable priority queue: one ring buffer per priority class in a single memory.
// An enqueue or an empty dequeue answers in the cycle after accept; a dequeue that removes
// an entry answers once the read port and then the response register hold its value.
// Enqueues can be accepted every cycle while the receiver takes each response; no request
// is taken during a dequeue's memory read. A response held back by the receiver blocks
// the next word until it leaves. Synchronous reset clears counts and pointers, not the memory.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic  clock,
   input  logic  reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MEM_D  = NUM_CLASSES * QUEUE_DEPTH;
   localparam int unsigned ADDR_W = $clog2(MEM_D);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type           state_ff;
   logic                out_valid_ff;
   status_type          out_status_ff;
   logic [VALUE_W-1:0]  out_value_ff;
   logic [PRIO_W-1:0]   out_prio_ff;
   logic [OCC_W-1:0]    out_occ_ff;
   logic [PRIO_W-1:0]   deq_prio_ff;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    class_cnt_ff [NUM_CLASSES];
   logic [CNT_W-1:0]    class_cnt_in [NUM_CLASSES];
   logic [PTR_W-1:0]    head_ff [NUM_CLASSES];
   logic [PTR_W-1:0]    head_in [NUM_CLASSES];
   logic [PTR_W-1:0]    tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0]    tail_in [NUM_CLASSES];

   logic                accept;
   logic                is_deq;
   logic                full;
   logic                empty;
   logic [PRIO_W-1:0]   prio_clamped;
   logic [CLS_W-1:0]    enq_cls;
   logic [CLS_W-1:0]    deq_cls;
   logic                do_enq;
   logic                do_deq;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  rd_data;

   // handshake and request decode
   assign req.ready = (state_ff == S_IDLE) && (!out_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign is_deq    = (req.operation == OP_DEQUEUE);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_enq    = accept && !is_deq && !full;
   assign do_deq    = accept && is_deq && !empty;

   // clamp the priority into range and map it to a class
   always_comb begin
      prio_clamped = req.item_priority;
      if (req.item_priority < PRIO_MIN) begin
         prio_clamped = PRIO_MIN;
      end else if (req.item_priority > PRIO_MAX) begin
         prio_clamped = PRIO_MAX;
      end
      enq_cls = CLS_W'(prio_clamped - PRIO_MIN);
   end

   // highest non-empty class leaves first
   always_comb begin
      deq_cls = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (class_cnt_ff[c] != '0) begin
            deq_cls = CLS_W'(c);
         end
      end
   end

   // memory addresses: class base plus ring pointer
   assign wr_addr = ADDR_W'(enq_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_ff[enq_cls]);
   assign rd_addr = ADDR_W'(deq_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[deq_cls]);

   // next counts and pointers
   always_comb begin
      count_in     = count_ff;
      class_cnt_in = class_cnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      if (do_enq) begin
         count_in              = count_ff + 1'b1;
         class_cnt_in[enq_cls] = class_cnt_ff[enq_cls] + 1'b1;
         tail_in[enq_cls]      = (tail_ff[enq_cls] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : tail_ff[enq_cls] + 1'b1;
      end
      if (do_deq) begin
         count_in              = count_ff - 1'b1;
         class_cnt_in[deq_cls] = class_cnt_ff[deq_cls] - 1'b1;
         head_in[deq_cls]      = (head_ff[deq_cls] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : head_ff[deq_cls] + 1'b1;
      end
   end

   // count and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            class_cnt_ff[c] <= '0;
            head_ff[c]      <= '0;
            tail_ff[c]      <= '0;
         end
      end else begin
         count_ff     <= count_in;
         class_cnt_ff <= class_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   // value memory, all classes side by side
   spq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MEM_D)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (do_enq),
      .wr_addr (wr_addr),
      .wr_data (req.item_value),
      .rd_en   (do_deq),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // state machine and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (do_deq) begin
                  state_ff    <= S_READ;
                  deq_prio_ff <= PRIO_W'(deq_cls) + PRIO_MIN;
               end
               if (accept && !do_deq) begin
                  out_valid_ff  <= 1'b1;
                  out_status_ff <= is_deq ? ST_EMPTY : (full ? ST_FULL : ST_DONE);
                  out_value_ff  <= '0;
                  out_prio_ff   <= '0;
                  out_occ_ff    <= OCC_W'(count_in);
               end else if (rsp.ready) begin
                  out_valid_ff <= 1'b0;
               end
            end
            S_READ: begin
               state_ff      <= S_IDLE;
               out_valid_ff  <= 1'b1;
               out_status_ff <= ST_DONE;
               out_value_ff  <= rd_data;
               out_prio_ff   <= deq_prio_ff;
               out_occ_ff    <= OCC_W'(count_ff);
            end
            default: begin
               state_ff <= S_IDLE;
               if (rsp.ready) begin
                  out_valid_ff <= 1'b0;
               end
            end
         endcase
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.out_value    = out_value_ff;
   assign rsp.out_priority = out_prio_ff;
   assign rsp.occupancy    = out_occ_ff;

`ifndef SYNTHESIS
   // stored count never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("stored count above queue depth");

   // class counts add up to the stored count
   assert property (@(posedge clock) disable iff (reset)
      (32'(class_cnt_ff[0]) + 32'(class_cnt_ff[1]) + 32'(class_cnt_ff[2]) +
       32'(class_cnt_ff[3]) + 32'(class_cnt_ff[4])) == 32'(count_ff))
      else $error("class counts disagree with stored count");

   // the read cycle always finds the response register free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !out_valid_ff)
      else $error("response register busy during memory read");

   // a successful dequeue is followed by a read cycle
   assert property (@(posedge clock) disable iff (reset)
      do_deq |=> (state_ff == S_READ))
      else $error("dequeue did not enter read cycle");
`endif

endmodule

@@ verif/stable_priority_queue_tb.sv @@
// self-checking testbench of the stable priority queue with its own queue predictor
module stable_priority_queue_tb
   import spq_pkg::*;
();

   localparam int unsigned DEPTH      = DEFAULT_QUEUE_DEPTH;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned END_WAIT   = 8;

   // one response word as the predictor works it out
   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]  prio;
      logic [OCC_W-1:0]   occupancy;
   } rsp_word_type;

   logic clock;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   stable_priority_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   // predicted queue contents, head at index 0
   logic [VALUE_W-1:0] queued_value [DEPTH];
   logic [PRIO_W-1:0]  queued_prio  [DEPTH];
   int unsigned        queued_count;

   rsp_word_type pending_rsp [$];
   int unsigned req_gap_pct;
   int unsigned rsp_stall_pct;
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned enqueue_count;
   int unsigned dequeue_count;
   int unsigned full_hits;
   int unsigned empty_hits;
   int unsigned peak_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // compute the response of one accepted word and update the predicted contents
   task automatic predict_response(input op_type op, input logic [VALUE_W-1:0] value,
                                   input logic [PRIO_W-1:0] prio);
      rsp_word_type word;
      int unsigned slot;
      logic [PRIO_W-1:0] p;
      word.status = ST_DONE;
      word.value  = '0;
      word.prio   = '0;
      p = prio;
      if (op == OP_ENQUEUE) begin
         enqueue_count++;
         if (queued_count >= DEPTH) begin
            word.status = ST_FULL;
            full_hits++;
         end else begin
            // out-of-range priorities are clamped into 1..5
            if (p < PRIO_MIN) p = PRIO_MIN;
            if (p > PRIO_MAX) p = PRIO_MAX;
            // new entry goes behind every entry of equal or higher priority
            slot = 0;
            while (slot < queued_count && queued_prio[slot] >= p) slot++;
            for (int i = int'(queued_count); i > int'(slot); i--) begin
               queued_value[i] = queued_value[i-1];
               queued_prio[i]  = queued_prio[i-1];
            end
            queued_value[slot] = value;
            queued_prio[slot]  = p;
            queued_count++;
            if (queued_count > peak_count) peak_count = queued_count;
         end
      end else begin
         dequeue_count++;
         if (queued_count == 0) begin
            word.status = ST_EMPTY;
            empty_hits++;
         end else begin
            word.value = queued_value[0];
            word.prio  = queued_prio[0];
            for (int i = 1; i < int'(queued_count); i++) begin
               queued_value[i-1] = queued_value[i];
               queued_prio[i-1]  = queued_prio[i];
            end
            queued_count--;
         end
      end
      word.occupancy = queued_count[OCC_W-1:0];
      pending_rsp.push_back(word);
   endtask

   // send one request word, with random sender gaps, and predict it once accepted
   task automatic send_word(input op_type op, input logic [VALUE_W-1:0] value,
                            input logic [PRIO_W-1:0] prio);
      while ($urandom_range(99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.operation     <= op;
      req_if.item_value    <= value;
      req_if.item_priority <= prio;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
      predict_response(op, value, prio);
   endtask

   // hold the sender off until every predicted response has come back
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // dequeue on an empty queue
   task automatic test_empty_dequeue();
      send_word(OP_DEQUEUE, 8'hFF, 3'd7);
   endtask

   // one entry of every priority code, clamping of 0, 6 and 7
   task automatic test_priority_order();
      logic [VALUE_W-1:0] values [8];
      values = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
      for (int i = 0; i < 8; i++) send_word(OP_ENQUEUE, values[i], 3'(i));
   endtask

   // ties keep arrival order, then an enqueue on a full queue, then some dequeues
   task automatic test_ties_and_full();
      for (int i = 0; i < 8; i++) send_word(OP_ENQUEUE, 8'(8'h10 + i), 3'd3);
      send_word(OP_ENQUEUE, 8'hFF, 3'd7);
      for (int i = 0; i < 6; i++) send_word(OP_DEQUEUE, 8'h00, 3'd0);
   endtask

   // runs biased toward filling, emptying or mixing, with random content
   task automatic test_random_traffic(input int unsigned n_words);
      int unsigned left;
      int unsigned run;
      int unsigned mode;
      int unsigned enq_pct;
      op_type      op;
      logic [PRIO_W-1:0] prio;
      left = n_words;
      while (left > 0) begin
         run  = $urandom_range(40, 8);
         mode = $urandom_range(2);
         case (mode)
            0: begin
               enq_pct = 85;
            end
            1: begin
               enq_pct = 20;
            end
            default: begin
               enq_pct = 50;
            end
         endcase
         for (int k = 0; k < int'(run) && left > 0; k++) begin
            op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            // mostly legal priorities, a narrow set now and then for many ties
            if ($urandom_range(9) == 0) prio = 3'($urandom_range(7));
            else if (mode == 2) prio = 3'($urandom_range(3, 2));
            else prio = 3'($urandom_range(5, 1));
            send_word(op, 8'($urandom_range(255)), prio);
            left--;
         end
      end
   endtask

   // response ready with random stalls
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // compare each accepted response word with the oldest prediction
   always @(negedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing pending: status %0d value %0d",
                   rsp_if.status, rsp_if.out_value);
            error_count++;
         end else begin
            exp_word = pending_rsp.pop_front();
            if (rsp_if.status !== exp_word.status) begin
               $error("status expected %0d got %0d", exp_word.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.out_value !== exp_word.value) begin
               $error("out_value expected %0d got %0d", exp_word.value, rsp_if.out_value);
               error_count++;
            end
            if (rsp_if.out_priority !== exp_word.prio) begin
               $error("out_priority expected %0d got %0d", exp_word.prio,
                      rsp_if.out_priority);
               error_count++;
            end
            if (rsp_if.occupancy !== exp_word.occupancy) begin
               $error("occupancy expected %0d got %0d", exp_word.occupancy,
                      rsp_if.occupancy);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles in which no word moves on either channel
   always @(negedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("stable_priority_queue_tb: errors");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.operation     = OP_ENQUEUE;
      req_if.item_value    = '0;
      req_if.item_priority = '0;
      queued_count         = 0;
      enqueue_count        = 0;
      dequeue_count        = 0;
      full_hits            = 0;
      empty_hits           = 0;
      peak_count           = 0;
      req_gap_pct          = 0;
      rsp_stall_pct        = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with a slow receiver
      req_gap_pct   = 6;
      rsp_stall_pct = 75;
      test_empty_dequeue();
      test_priority_order();
      test_ties_and_full();
      wait_for_drain();

      // random part, three idling profiles
      test_random_traffic(160);
      wait_for_drain();
      req_gap_pct   = 75;
      rsp_stall_pct = 6;
      test_random_traffic(160);
      wait_for_drain();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_random_traffic(160);

      wait_for_drain();
      repeat (END_WAIT) @(posedge clock);

      $display("covered %0d enqueues and %0d dequeues, peak fill %0d of %0d",
               enqueue_count, dequeue_count, peak_count, DEPTH);
      $display("enqueues refused as full: %0d, dequeues found empty: %0d",
               full_hits, empty_hits);
      if (error_count == 0) begin
         $display("stable_priority_queue_tb: clean");
      end else begin
         $display("stable_priority_queue_tb: errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/spq_pkg.sv
rtl/spq_channels_if.sv
rtl/spq_ram.sv
rtl/stable_priority_queue.sv
verif/stable_priority_queue_tb.sv
